>>> rtl/gc2d_pkg.sv
// Shared types, register codes and defaults for the grouped 2-D convolution block.
`default_nettype none
package gc2d_pkg;

   localparam int DefActDepth    = 4096;
   localparam int DefWeightDepth = 4096;
   localparam int DefMaxChannels = 64;
   localparam int DefDataWidth   = 32;

   localparam int CsrIndexWidth = 3;
   localparam int CsrDataWidth  = 13;

   localparam logic [CsrIndexWidth-1:0] CFG_IN_CHANNELS  = 3'd0;
   localparam logic [CsrIndexWidth-1:0] CFG_OUT_CHANNELS = 3'd1;
   localparam logic [CsrIndexWidth-1:0] CFG_GROUPS       = 3'd2;
   localparam logic [CsrIndexWidth-1:0] CFG_IN_HEIGHT    = 3'd3;
   localparam logic [CsrIndexWidth-1:0] CFG_IN_WIDTH     = 3'd4;
   localparam logic [CsrIndexWidth-1:0] CFG_KERNEL_SHAPE = 3'd5;
   localparam logic [CsrIndexWidth-1:0] CFG_STRIDE_SHAPE = 3'd6;
   localparam logic [CsrIndexWidth-1:0] CFG_PAD_SHAPE    = 3'd7;

   localparam logic [1:0] KIND_LOAD_ACT    = 2'd0;
   localparam logic [1:0] KIND_LOAD_WEIGHT = 2'd1;
   localparam logic [1:0] KIND_LOAD_BIAS   = 2'd2;
   localparam logic [1:0] KIND_COMPUTE     = 2'd3;

   localparam logic [6:0]  RST_CHANNELS = 7'd1;
   localparam logic [12:0] RST_SIZE     = 13'd1;
   localparam logic [7:0]  RST_SHAPE    = 8'h11;
   localparam logic [7:0]  RST_PAD      = 8'h00;

   typedef enum logic [4:0] {
      S_IDLE, S_PREP, S_CHECK, S_DIV_IN, S_WAIT_IN, S_DIV_OUT, S_WAIT_OUT, S_GATE,
      S_DIV_GRP, S_WAIT_GRP, S_INIT1, S_INIT2, S_INIT3, S_ROW1, S_ROW2, S_TAP,
      S_READ, S_ACC, S_FINISH
   } state_type;

   typedef enum logic [4:0] {
      OP_NONE, OP_LATCH, OP_PREP, OP_CHECK, OP_DIV_IN, OP_DIV_OUT, OP_DIV_GRP,
      OP_DIV_STEP, OP_SAVE_IPG, OP_SAVE_OPG, OP_SAVE_GRP, OP_INIT1, OP_INIT2,
      OP_INIT3, OP_ROW1, OP_ROW2, OP_SKIP_ROW, OP_TAP, OP_READ, OP_ACC, OP_EMIT
   } dp_op_type;

   typedef struct packed {
      dp_op_type op;
   } cmd_type;

   typedef struct packed {
      logic div_done;
      logic bad;
      logic row_ok;
      logic last_col;
      logic last_row;
      logic last_icg;
      logic out_free;
   } status_type;

endpackage
`default_nettype wire

>>> rtl/grouped_conv2d_int32_top.sv
// Top level of the grouped 2-D integer convolution block.
// Usage: requests arrive on req_valid/req_stall. Load requests (kind 0, 1, 2) write
// req_value into the activation, weight or bias store at req_address and produce no
// response. A compute request (kind 3) names an output channel, row and column and
// produces exactly one response on rsp_valid/rsp_stall with the bias plus the
// multiply-accumulate sum, or zero with rsp_bad_position set when the configuration
// or position is unusable.
// Work of a compute request: setup (range checks and up to three divisions for the
// group mapping), then states ROW1 and ROW2 for each kernel row of each group input
// channel, plus states TAP, READ and ACC for each tap in rows inside the input:
// address and memory read, multiply, accumulate, all through one multiplier and the
// single read port of each store. One request is worked on at a time; req_stall is
// high while a computation runs. The finished result sits in an output register;
// while rsp_stall holds it, further requests are still taken, and the next compute
// request waits at its end until the register is free. Reset (synchronous, active
// high) clears the control state, the output valid and the configuration registers
// to their defaults; store contents are undefined until written. Configuration is to
// be written through csr_* only while idle; the block itself does not enforce this.
`default_nettype none
module grouped_conv2d_int32_top #(
   parameter int ACT_DEPTH    = gc2d_pkg::DefActDepth,
   parameter int WEIGHT_DEPTH = gc2d_pkg::DefWeightDepth,
   parameter int MAX_CHANNELS = gc2d_pkg::DefMaxChannels,
   parameter int DATA_WIDTH   = gc2d_pkg::DefDataWidth
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_valid,
   output logic                                    req_stall,
   input  wire logic [1:0]                         req_kind,
   input  wire logic [11:0]                        req_address,
   input  wire logic signed [31:0]                 req_value,
   input  wire logic [5:0]                         req_out_channel,
   input  wire logic [11:0]                        req_out_row,
   input  wire logic [11:0]                        req_out_col,
   output logic                                    rsp_valid,
   input  wire logic                               rsp_stall,
   output logic signed [31:0]                      rsp_result,
   output logic                                    rsp_bad_position,
   input  wire logic                               csr_write,
   input  wire logic [gc2d_pkg::CsrIndexWidth-1:0] csr_index,
   input  wire logic [gc2d_pkg::CsrDataWidth-1:0]  csr_wdata
);

   gc2d_pkg::cmd_type    cmd;
   gc2d_pkg::status_type status;

   gc2d_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_kind  (req_kind),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   gc2d_dp #(
      .ACT_DEPTH    (ACT_DEPTH),
      .WEIGHT_DEPTH (WEIGHT_DEPTH),
      .MAX_CHANNELS (MAX_CHANNELS),
      .DATA_WIDTH   (DATA_WIDTH)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .req_kind         (req_kind),
      .req_address      (req_address),
      .req_value        (req_value),
      .req_out_channel  (req_out_channel),
      .req_out_row      (req_out_row),
      .req_out_col      (req_out_col),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_result       (rsp_result),
      .rsp_bad_position (rsp_bad_position),
      .csr_write        (csr_write),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

endmodule
`default_nettype wire

>>> rtl/gc2d_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module gc2d_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 4096,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

>>> rtl/gc2d_ctrl.sv
// Controller state machine that sequences loads, checks and the tap loop.
`default_nettype none
module gc2d_ctrl (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   input  wire logic [1:0]          req_kind,
   output logic                     req_stall,
   input  wire gc2d_pkg::status_type status,
   output gc2d_pkg::cmd_type        cmd
);

   gc2d_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= gc2d_pkg::S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd.op    = gc2d_pkg::OP_NONE;
      req_stall = 1'b1;
      case (state_ff)
         gc2d_pkg::S_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.op = gc2d_pkg::OP_LATCH;
               if (req_kind == gc2d_pkg::KIND_COMPUTE) begin
                  state_in = gc2d_pkg::S_PREP;
               end
            end
         end
         gc2d_pkg::S_PREP: begin
            cmd.op   = gc2d_pkg::OP_PREP;
            state_in = gc2d_pkg::S_CHECK;
         end
         gc2d_pkg::S_CHECK: begin
            cmd.op   = gc2d_pkg::OP_CHECK;
            state_in = gc2d_pkg::S_DIV_IN;
         end
         gc2d_pkg::S_DIV_IN: begin
            cmd.op   = gc2d_pkg::OP_DIV_IN;
            state_in = gc2d_pkg::S_WAIT_IN;
         end
         gc2d_pkg::S_WAIT_IN: begin
            if (status.div_done) begin
               cmd.op   = gc2d_pkg::OP_SAVE_IPG;
               state_in = gc2d_pkg::S_DIV_OUT;
            end else begin
               cmd.op = gc2d_pkg::OP_DIV_STEP;
            end
         end
         gc2d_pkg::S_DIV_OUT: begin
            cmd.op   = gc2d_pkg::OP_DIV_OUT;
            state_in = gc2d_pkg::S_WAIT_OUT;
         end
         gc2d_pkg::S_WAIT_OUT: begin
            if (status.div_done) begin
               cmd.op   = gc2d_pkg::OP_SAVE_OPG;
               state_in = gc2d_pkg::S_GATE;
            end else begin
               cmd.op = gc2d_pkg::OP_DIV_STEP;
            end
         end
         gc2d_pkg::S_GATE: begin
            // Any unusable configuration or position ends the request here.
            state_in = status.bad ? gc2d_pkg::S_FINISH : gc2d_pkg::S_DIV_GRP;
         end
         gc2d_pkg::S_DIV_GRP: begin
            cmd.op   = gc2d_pkg::OP_DIV_GRP;
            state_in = gc2d_pkg::S_WAIT_GRP;
         end
         gc2d_pkg::S_WAIT_GRP: begin
            if (status.div_done) begin
               cmd.op   = gc2d_pkg::OP_SAVE_GRP;
               state_in = gc2d_pkg::S_INIT1;
            end else begin
               cmd.op = gc2d_pkg::OP_DIV_STEP;
            end
         end
         gc2d_pkg::S_INIT1: begin
            cmd.op   = gc2d_pkg::OP_INIT1;
            state_in = gc2d_pkg::S_INIT2;
         end
         gc2d_pkg::S_INIT2: begin
            cmd.op   = gc2d_pkg::OP_INIT2;
            state_in = gc2d_pkg::S_INIT3;
         end
         gc2d_pkg::S_INIT3: begin
            cmd.op   = gc2d_pkg::OP_INIT3;
            state_in = gc2d_pkg::S_ROW1;
         end
         gc2d_pkg::S_ROW1: begin
            cmd.op   = gc2d_pkg::OP_ROW1;
            state_in = gc2d_pkg::S_ROW2;
         end
         gc2d_pkg::S_ROW2: begin
            if (status.row_ok) begin
               cmd.op   = gc2d_pkg::OP_ROW2;
               state_in = gc2d_pkg::S_TAP;
            end else begin
               cmd.op = gc2d_pkg::OP_SKIP_ROW;
               if (status.last_row && status.last_icg) begin
                  state_in = gc2d_pkg::S_FINISH;
               end else begin
                  state_in = gc2d_pkg::S_ROW1;
               end
            end
         end
         gc2d_pkg::S_TAP: begin
            cmd.op   = gc2d_pkg::OP_TAP;
            state_in = gc2d_pkg::S_READ;
         end
         gc2d_pkg::S_READ: begin
            cmd.op   = gc2d_pkg::OP_READ;
            state_in = gc2d_pkg::S_ACC;
         end
         gc2d_pkg::S_ACC: begin
            cmd.op = gc2d_pkg::OP_ACC;
            if (!status.last_col) begin
               state_in = gc2d_pkg::S_TAP;
            end else if (status.last_row && status.last_icg) begin
               state_in = gc2d_pkg::S_FINISH;
            end else begin
               state_in = gc2d_pkg::S_ROW1;
            end
         end
         gc2d_pkg::S_FINISH: begin
            if (status.out_free) begin
               cmd.op   = gc2d_pkg::OP_EMIT;
               state_in = gc2d_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = gc2d_pkg::S_IDLE;
         end
      endcase
   end

`ifndef NO_ASSERTIONS
   a_tap_order: assert property (@(posedge clock) disable iff (reset)
      state_ff == gc2d_pkg::S_TAP |=> state_ff == gc2d_pkg::S_READ)
      else $error("tap read did not follow address phase");
   a_emit_free: assert property (@(posedge clock) disable iff (reset)
      cmd.op == gc2d_pkg::OP_EMIT |-> status.out_free)
      else $error("result emitted into an occupied output register");
   a_busy_stall: assert property (@(posedge clock) disable iff (reset)
      state_ff == gc2d_pkg::S_ACC |-> req_stall)
      else $error("request accepted during accumulation");
`endif

endmodule
`default_nettype wire

>>> rtl/gc2d_dp.sv
// Datapath: configuration, stores, divider, index arithmetic, MAC and output register.
`default_nettype none
module gc2d_dp #(
   parameter int ACT_DEPTH    = gc2d_pkg::DefActDepth,
   parameter int WEIGHT_DEPTH = gc2d_pkg::DefWeightDepth,
   parameter int MAX_CHANNELS = gc2d_pkg::DefMaxChannels,
   parameter int DATA_WIDTH   = gc2d_pkg::DefDataWidth
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire gc2d_pkg::cmd_type                   cmd,
   output gc2d_pkg::status_type                     status,
   input  wire logic [1:0]                          req_kind,
   input  wire logic [11:0]                         req_address,
   input  wire logic signed [31:0]                  req_value,
   input  wire logic [5:0]                          req_out_channel,
   input  wire logic [11:0]                         req_out_row,
   input  wire logic [11:0]                         req_out_col,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_stall,
   output logic signed [31:0]                       rsp_result,
   output logic                                     rsp_bad_position,
   input  wire logic                                csr_write,
   input  wire logic [gc2d_pkg::CsrIndexWidth-1:0]  csr_index,
   input  wire logic [gc2d_pkg::CsrDataWidth-1:0]   csr_wdata
);

   localparam int AAW = (ACT_DEPTH > 1) ? $clog2(ACT_DEPTH) : 1;
   localparam int WAW = (WEIGHT_DEPTH > 1) ? $clog2(WEIGHT_DEPTH) : 1;
   localparam int BAW = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;

   // Configuration registers.
   logic [6:0]  in_ch_ff, out_ch_ff, groups_ff;
   logic [12:0] in_h_ff, in_w_ff;
   logic [7:0]  kshape_ff, sshape_ff, pshape_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_ch_ff  <= gc2d_pkg::RST_CHANNELS;
         out_ch_ff <= gc2d_pkg::RST_CHANNELS;
         groups_ff <= gc2d_pkg::RST_CHANNELS;
         in_h_ff   <= gc2d_pkg::RST_SIZE;
         in_w_ff   <= gc2d_pkg::RST_SIZE;
         kshape_ff <= gc2d_pkg::RST_SHAPE;
         sshape_ff <= gc2d_pkg::RST_SHAPE;
         pshape_ff <= gc2d_pkg::RST_PAD;
      end else if (csr_write) begin
         case (csr_index)
            gc2d_pkg::CFG_IN_CHANNELS:  in_ch_ff  <= csr_wdata[6:0];
            gc2d_pkg::CFG_OUT_CHANNELS: out_ch_ff <= csr_wdata[6:0];
            gc2d_pkg::CFG_GROUPS:       groups_ff <= csr_wdata[6:0];
            gc2d_pkg::CFG_IN_HEIGHT:    in_h_ff   <= csr_wdata;
            gc2d_pkg::CFG_IN_WIDTH:     in_w_ff   <= csr_wdata;
            gc2d_pkg::CFG_KERNEL_SHAPE: kshape_ff <= csr_wdata[7:0];
            gc2d_pkg::CFG_STRIDE_SHAPE: sshape_ff <= csr_wdata[7:0];
            gc2d_pkg::CFG_PAD_SHAPE:    pshape_ff <= csr_wdata[7:0];
            default: begin
            end
         endcase
      end
   end

   logic [3:0] kh, kw, sh, sw, ph, pw;
   assign kh = kshape_ff[7:4];
   assign kw = kshape_ff[3:0];
   assign sh = sshape_ff[7:4];
   assign sw = sshape_ff[3:0];
   assign ph = pshape_ff[7:4];
   assign pw = pshape_ff[3:0];

   // Stores: loads write at request acceptance.
   logic        latch;
   logic [31:0] addr32;
   logic        act_we, wgt_we, bias_we;
   assign latch   = (cmd.op == gc2d_pkg::OP_LATCH);
   assign addr32  = 32'(req_address);
   assign act_we  = latch && (req_kind == gc2d_pkg::KIND_LOAD_ACT)
                    && (addr32 < 32'(ACT_DEPTH));
   assign wgt_we  = latch && (req_kind == gc2d_pkg::KIND_LOAD_WEIGHT)
                    && (addr32 < 32'(WEIGHT_DEPTH));
   assign bias_we = latch && (req_kind == gc2d_pkg::KIND_LOAD_BIAS)
                    && (addr32 < 32'(MAX_CHANNELS));

   logic [5:0]  oc_ff;
   logic [11:0] orow_ff, ocol_ff;
   logic [33:0] rowoff_ff;
   logic [20:0] wi_ff;
   logic [3:0]  c_ff, r_ff;
   logic [6:0]  icg_ff;
   logic signed [17:0] col_base_ff, row_base_ff;
   logic signed [17:0] iw;
   logic [33:0] ai;
   logic [31:0] oc32;
   logic [DATA_WIDTH-1:0] act_rd, wgt_rd, bias_rd;

   assign iw   = col_base_ff + $signed({14'd0, c_ff});
   assign ai   = rowoff_ff + 34'(iw[12:0]);
   assign oc32 = 32'(oc_ff);

   gc2d_ram #(.WIDTH(DATA_WIDTH), .DEPTH(ACT_DEPTH)) u_act_ram (
      .clock   (clock),
      .wr_en   (act_we),
      .wr_addr (addr32[AAW-1:0]),
      .wr_data (req_value[DATA_WIDTH-1:0]),
      .rd_addr (ai[AAW-1:0]),
      .rd_data (act_rd)
   );

   gc2d_ram #(.WIDTH(DATA_WIDTH), .DEPTH(WEIGHT_DEPTH)) u_wgt_ram (
      .clock   (clock),
      .wr_en   (wgt_we),
      .wr_addr (addr32[WAW-1:0]),
      .wr_data (req_value[DATA_WIDTH-1:0]),
      .rd_addr (wi_ff[WAW-1:0]),
      .rd_data (wgt_rd)
   );

   gc2d_ram #(.WIDTH(DATA_WIDTH), .DEPTH(MAX_CHANNELS)) u_bias_ram (
      .clock   (clock),
      .wr_en   (bias_we),
      .wr_addr (addr32[BAW-1:0]),
      .wr_data (req_value[DATA_WIDTH-1:0]),
      .rd_addr (oc32[BAW-1:0]),
      .rd_data (bias_rd)
   );

   logic signed [31:0] act_s, wgt_s, bias_s;
   assign act_s  = 32'($signed(act_rd));
   assign wgt_s  = 32'($signed(wgt_rd));
   assign bias_s = 32'($signed(bias_rd));

   // Request fields and position products.
   logic [15:0] rprod_ff, cprod_ff;

   always_ff @(posedge clock) begin
      if (latch) begin
         oc_ff   <= req_out_channel;
         orow_ff <= req_out_row;
         ocol_ff <= req_out_col;
      end
      if (cmd.op == gc2d_pkg::OP_PREP) begin
         rprod_ff <= 16'(orow_ff) * 16'(sh);
         cprod_ff <= 16'(ocol_ff) * 16'(sw);
      end
   end

   // Range checks. A position is inside the output when pos*stride <= span - kernel.
   logic [14:0] span_h, span_w;
   logic        cfg_bad, pos_bad;
   assign span_h = 15'(in_h_ff) + 15'({ph, 1'b0});
   assign span_w = 15'(in_w_ff) + 15'({pw, 1'b0});

   always_comb begin
      cfg_bad = (in_ch_ff == '0) || (out_ch_ff == '0) || (groups_ff == '0)
                || (32'(in_ch_ff) > 32'(MAX_CHANNELS))
                || (32'(out_ch_ff) > 32'(MAX_CHANNELS))
                || (kh == '0) || (kw == '0) || (sh == '0) || (sw == '0)
                || (in_h_ff == '0) || (in_w_ff == '0);
      pos_bad = (7'(oc_ff) >= out_ch_ff)
                || (span_h < 15'(kh)) || (17'(rprod_ff) > 17'(span_h - 15'(kh)))
                || (span_w < 15'(kw)) || (17'(cprod_ff) > 17'(span_w - 15'(kw)));
   end

   // Shared restoring divider, one quotient bit per cycle.
   logic [6:0] quo_ff, quo_in, den_ff, den_in;
   logic [7:0] rem_ff, rem_in, shifted;
   logic [2:0] cnt_ff, cnt_in;
   logic       ge;
   logic [6:0] ipg_ff, opg_ff, grp_idx_ff, start_ff;
   logic       bad_ff;

   assign shifted = {rem_ff[6:0], quo_ff[6]};
   assign ge      = shifted >= {1'b0, den_ff};

   always_comb begin
      quo_in = quo_ff;
      rem_in = rem_ff;
      den_in = den_ff;
      cnt_in = cnt_ff;
      case (cmd.op)
         gc2d_pkg::OP_DIV_IN: begin
            quo_in = in_ch_ff;
            den_in = groups_ff;
            rem_in = '0;
            cnt_in = 3'd7;
         end
         gc2d_pkg::OP_DIV_OUT: begin
            quo_in = out_ch_ff;
            den_in = groups_ff;
            rem_in = '0;
            cnt_in = 3'd7;
         end
         gc2d_pkg::OP_DIV_GRP: begin
            quo_in = 7'(oc_ff);
            den_in = opg_ff;
            rem_in = '0;
            cnt_in = 3'd7;
         end
         gc2d_pkg::OP_DIV_STEP: begin
            rem_in = ge ? (shifted - {1'b0, den_ff}) : shifted;
            quo_in = {quo_ff[5:0], ge};
            cnt_in = cnt_ff - 3'd1;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
      cnt_ff <= cnt_in;
   end

   // Loop counters, index registers and accumulator.
   logic [19:0] chanh_ff;
   logic signed [17:0] ih_ff, ih;
   logic        row_ok_ff, tap_ok_ff, a_ok_ff, w_ok_ff, col_ok;
   logic [31:0] prod_ff, sum_ff;
   logic        last_col, last_row, last_icg;
   logic [19:0] rowsum;

   assign ih       = row_base_ff + $signed({14'd0, r_ff});
   assign col_ok   = !iw[17] && (iw < $signed({5'd0, in_w_ff}));
   assign last_col = (c_ff == kw - 4'd1);
   assign last_row = (r_ff == kh - 4'd1);
   assign last_icg = (icg_ff == ipg_ff - 7'd1);
   assign rowsum   = chanh_ff + 20'(ih_ff[12:0]);

   always_ff @(posedge clock) begin
      case (cmd.op)
         gc2d_pkg::OP_CHECK: begin
            bad_ff      <= cfg_bad || pos_bad;
            sum_ff      <= bias_s;
            row_base_ff <= $signed({2'd0, rprod_ff}) - $signed({14'd0, ph});
            col_base_ff <= $signed({2'd0, cprod_ff}) - $signed({14'd0, pw});
         end
         gc2d_pkg::OP_SAVE_IPG: begin
            ipg_ff <= quo_ff;
            if (rem_ff != '0) bad_ff <= 1'b1;
         end
         gc2d_pkg::OP_SAVE_OPG: begin
            opg_ff <= quo_ff;
            if (rem_ff != '0) bad_ff <= 1'b1;
         end
         gc2d_pkg::OP_SAVE_GRP: begin
            grp_idx_ff <= quo_ff;
         end
         gc2d_pkg::OP_INIT1: begin
            start_ff <= 7'(14'(grp_idx_ff) * 14'(ipg_ff));
            wi_ff    <= 21'(oc_ff) * 21'(ipg_ff);
            icg_ff   <= '0;
            r_ff     <= '0;
            c_ff     <= '0;
         end
         gc2d_pkg::OP_INIT2: begin
            wi_ff <= wi_ff * 21'(kh);
         end
         gc2d_pkg::OP_INIT3: begin
            wi_ff <= wi_ff * 21'(kw);
         end
         gc2d_pkg::OP_ROW1: begin
            chanh_ff  <= 20'(start_ff + icg_ff) * 20'(in_h_ff);
            ih_ff     <= ih;
            row_ok_ff <= !ih[17] && (ih < $signed({5'd0, in_h_ff}));
         end
         gc2d_pkg::OP_ROW2: begin
            rowoff_ff <= 34'(rowsum) * 34'(in_w_ff);
         end
         gc2d_pkg::OP_SKIP_ROW: begin
            // The whole kernel row lies in the padding; its weights are passed over.
            wi_ff <= wi_ff + 21'(kw);
            c_ff  <= '0;
            if (last_row) begin
               r_ff   <= '0;
               icg_ff <= icg_ff + 7'd1;
            end else begin
               r_ff <= r_ff + 4'd1;
            end
         end
         gc2d_pkg::OP_TAP: begin
            tap_ok_ff <= col_ok;
            a_ok_ff   <= col_ok && (ai < 34'(ACT_DEPTH));
            w_ok_ff   <= wi_ff < 21'(WEIGHT_DEPTH);
         end
         gc2d_pkg::OP_READ: begin
            prod_ff <= 32'((a_ok_ff ? act_s : 32'sd0) * (w_ok_ff ? wgt_s : 32'sd0));
         end
         gc2d_pkg::OP_ACC: begin
            if (tap_ok_ff) sum_ff <= sum_ff + prod_ff;
            wi_ff <= wi_ff + 21'd1;
            if (last_col) begin
               c_ff <= '0;
               if (last_row) begin
                  r_ff   <= '0;
                  icg_ff <= icg_ff + 7'd1;
               end else begin
                  r_ff <= r_ff + 4'd1;
               end
            end else begin
               c_ff <= c_ff + 4'd1;
            end
         end
         default: begin
         end
      endcase
   end

   // Output register; a waiting result does not block new requests.
   logic        rsp_valid_ff, rsp_valid_in;
   logic [31:0] rsp_result_ff;
   logic        rsp_bad_ff;

   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (cmd.op == gc2d_pkg::OP_EMIT) rsp_valid_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      if (cmd.op == gc2d_pkg::OP_EMIT) begin
         rsp_result_ff <= bad_ff ? 32'd0 : sum_ff;
         rsp_bad_ff    <= bad_ff;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_result       = $signed(rsp_result_ff);
   assign rsp_bad_position = rsp_bad_ff;

   always_comb begin
      status.div_done = (cnt_ff == '0);
      status.bad      = bad_ff;
      status.row_ok   = row_ok_ff;
      status.last_col = last_col;
      status.last_row = last_row;
      status.last_icg = last_icg;
      status.out_free = !rsp_valid_ff || !rsp_stall;
   end

`ifndef NO_ASSERTIONS
   a_bad_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_bad_ff |-> rsp_result_ff == '0)
      else $error("flagged position carries a nonzero result");
   a_div_runs: assert property (@(posedge clock) disable iff (reset)
      cmd.op == gc2d_pkg::OP_DIV_IN |=> cnt_ff != '0)
      else $error("divider reported done right after start");
   a_emit_valid: assert property (@(posedge clock) disable iff (reset)
      cmd.op == gc2d_pkg::OP_EMIT |=> rsp_valid_ff)
      else $error("emitted result not presented");
`endif

endmodule
`default_nettype wire

>>> tb/tb.sv
// Self-checking testbench for the grouped 2-D integer convolution block.
`default_nettype none

typedef struct {
   logic [31:0] result;
   bit          bad;
} conv_out_type;

class conv_scoreboard;
   logic [31:0] act_mem[4096];
   logic [31:0] wt_mem[4096];
   logic [31:0] bias_mem[64];
   bit act_wr[4096];
   bit wt_wr[4096];
   bit bias_wr[64];
   int ich = 1, och = 1, grp = 1, ih_size = 1, iw_size = 1;
   int kh = 1, kw = 1, sh = 1, sw = 1, ph = 0, pw = 0;
   conv_out_type pending_q[$];
   int miss_act[$];
   int miss_wt[$];
   bit miss_bias;
   int errors, n_computes, n_flagged, n_loads, n_checked;

   function void write_reg(logic [2:0] idx, logic [12:0] data);
      case (idx)
         gc2d_pkg::CFG_IN_CHANNELS: ich = data[6:0];
         gc2d_pkg::CFG_OUT_CHANNELS: och = data[6:0];
         gc2d_pkg::CFG_GROUPS: grp = data[6:0];
         gc2d_pkg::CFG_IN_HEIGHT: ih_size = data;
         gc2d_pkg::CFG_IN_WIDTH: iw_size = data;
         gc2d_pkg::CFG_KERNEL_SHAPE: begin kh = data[7:4]; kw = data[3:0]; end
         gc2d_pkg::CFG_STRIDE_SHAPE: begin sh = data[7:4]; sw = data[3:0]; end
         gc2d_pkg::CFG_PAD_SHAPE: begin ph = data[7:4]; pw = data[3:0]; end
         default: begin end
      endcase
   endfunction

   function bit cfg_bad();
      return ich == 0 || och == 0 || grp == 0 || ich > 64 || och > 64 ||
             ich % grp != 0 || och % grp != 0 || kh == 0 || kw == 0 ||
             sh == 0 || sw == 0 || ih_size == 0 || iw_size == 0;
   endfunction

   function int span_out(int in_n, int pad, int k, int s);
      int span;
      span = in_n + 2 * pad;
      if (span < k || s == 0) return 0;
      return (span - k) / s + 1;
   endfunction

   function int out_rows();
      return span_out(ih_size, ph, kh, sh);
   endfunction

   function int out_cols();
      return span_out(iw_size, pw, kw, sw);
   endfunction

   function bit position_ok(int oc, int row, int col);
      if (cfg_bad()) return 0;
      return oc < och && row < out_rows() && col < out_cols();
   endfunction

   // Walks the kernel window; with collect set it only lists entries not yet loaded.
   function logic [31:0] walk(int oc, int row, int col, bit collect);
      int ipg, opg, start, ih, iw;
      longint ai, wi;
      logic [31:0] sum, a, w;
      ipg = ich / grp;
      opg = och / grp;
      start = (oc / opg) * ipg;
      sum = bias_mem[oc];
      if (collect && !bias_wr[oc]) miss_bias = 1;
      for (int icg = 0; icg < ipg; icg++)
         for (int r = 0; r < kh; r++) begin
            ih = row * sh + r - ph;
            if (ih < 0 || ih >= ih_size) continue;
            for (int c = 0; c < kw; c++) begin
               iw = col * sw + c - pw;
               if (iw < 0 || iw >= iw_size) continue;
               ai = ((longint'(start + icg)) * ih_size + ih) * iw_size + iw;
               wi = ((longint'(oc * ipg + icg)) * kh + r) * kw + c;
               a = 0;
               w = 0;
               if (ai < 4096) begin
                  if (collect && !act_wr[ai]) miss_act.push_back(int'(ai));
                  a = act_mem[ai];
               end
               if (wi < 4096) begin
                  if (collect && !wt_wr[wi]) miss_wt.push_back(int'(wi));
                  w = wt_mem[wi];
               end
               sum += a * w;
            end
         end
      return sum;
   endfunction

   function void gather(int oc, int row, int col);
      miss_act.delete();
      miss_wt.delete();
      miss_bias = 0;
      if (position_ok(oc, row, col)) void'(walk(oc, row, col, 1));
   endfunction

   function void note_request(logic [1:0] kind, logic [11:0] addr, logic [31:0] value,
                              int oc, int row, int col);
      conv_out_type e;
      case (kind)
         gc2d_pkg::KIND_LOAD_ACT: begin act_mem[addr] = value; act_wr[addr] = 1; end
         gc2d_pkg::KIND_LOAD_WEIGHT: begin wt_mem[addr] = value; wt_wr[addr] = 1; end
         gc2d_pkg::KIND_LOAD_BIAS:
            if (addr < 64) begin bias_mem[addr] = value; bias_wr[addr] = 1; end
         default: begin
            e.result = 0;
            e.bad = 1;
            if (position_ok(oc, row, col)) begin
               e.result = walk(oc, row, col, 0);
               e.bad = 0;
            end
            pending_q.push_back(e);
            n_computes++;
            if (e.bad) n_flagged++;
         end
      endcase
      if (kind != gc2d_pkg::KIND_COMPUTE) n_loads++;
   endfunction

   function void check_response(logic [31:0] result, logic bad);
      conv_out_type e;
      if (pending_q.size() == 0) begin
         $error("response with no request waiting: result %0d", $signed(result));
         errors++;
         return;
      end
      e = pending_q.pop_front();
      n_checked++;
      if (result !== e.result) begin
         $error("result expected %0d actual %0d", $signed(e.result), $signed(result));
         errors++;
      end
      if (bad !== e.bad) begin
         $error("bad_position expected %0d actual %0d", e.bad, bad);
         errors++;
      end
   endfunction
endclass

module tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CycleLimit = 3000000;
   localparam int RandomItems = 750;

   logic clock = 0;
   logic reset = 1;
   logic req_valid = 0;
   logic req_stall;
   logic [1:0] req_kind = 0;
   logic [11:0] req_address = 0;
   logic signed [31:0] req_value = 0;
   logic [5:0] req_out_channel = 0;
   logic [11:0] req_out_row = 0;
   logic [11:0] req_out_col = 0;
   logic rsp_valid;
   logic rsp_stall = 0;
   logic signed [31:0] rsp_result;
   logic rsp_bad_position;
   logic csr_write = 0;
   logic [gc2d_pkg::CsrIndexWidth-1:0] csr_index = 0;
   logic [gc2d_pkg::CsrDataWidth-1:0] csr_wdata = 0;

   conv_scoreboard sb = new();
   int cycles;
   int item_count;
   int phase_count;
   bit quiet;
   bit hold_req;

   grouped_conv2d_int32_top u_dut (.*);

   always #6 clock = ~clock;

   always @(posedge clock) begin
      cycles++;
      if (cycles > CycleLimit) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   always @(posedge clock)
      if (!reset && rsp_valid && !rsp_stall) sb.check_response(rsp_result, rsp_bad_position);

   function int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (quiet || r < 65) return 0;
      if (r < 95) return $urandom_range(1, 3);
      return $urandom_range(20, 60);
   endfunction

   // Receiver: random short stalls, a rare long one, and a long hold on request.
   initial begin
      int left;
      left = 0;
      forever begin
         @(negedge clock);
         if (hold_req) begin
            hold_req = 0;
            rsp_stall = 1;
            repeat (400) @(negedge clock);
            left = 0;
         end
         if (left > 0) begin
            left--;
            rsp_stall = 1;
         end else begin
            left = pick_gap();
            rsp_stall = left > 0;
            if (left > 0) left--;
         end
      end
   end

   task automatic send(logic [1:0] kind, logic [11:0] addr, logic [31:0] value,
                       logic [5:0] oc, logic [11:0] row, logic [11:0] col);
      int gap;
      gap = pick_gap();
      @(negedge clock);
      if (gap > 0) begin
         req_valid = 0;
         repeat (gap) @(negedge clock);
      end
      req_kind = kind;
      req_address = addr;
      req_value = value;
      req_out_channel = oc;
      req_out_row = row;
      req_out_col = col;
      req_valid = 1;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sb.note_request(kind, addr, value, oc, row, col);
      item_count++;
   endtask

   task automatic load(logic [1:0] kind, logic [11:0] addr, logic [31:0] value);
      send(kind, addr, value, $urandom, $urandom, $urandom);
   endtask

   // Loads whatever the computation would read that was never written, then computes.
   task automatic compute(logic [5:0] oc, logic [11:0] row, logic [11:0] col);
      int acts[$];
      int wts[$];
      sb.gather(oc, row, col);
      acts = sb.miss_act;
      wts = sb.miss_wt;
      if (sb.miss_bias) load(gc2d_pkg::KIND_LOAD_BIAS, 12'(oc), $urandom);
      foreach (acts[i]) load(gc2d_pkg::KIND_LOAD_ACT, 12'(acts[i]), $urandom);
      foreach (wts[i]) load(gc2d_pkg::KIND_LOAD_WEIGHT, 12'(wts[i]), $urandom);
      send(gc2d_pkg::KIND_COMPUTE, $urandom, $urandom, oc, row, col);
   endtask

   task automatic drain();
      @(negedge clock);
      req_valid = 0;
      while (sb.pending_q.size() != 0) @(posedge clock);
      repeat (80) @(posedge clock);
   endtask

   task automatic write_reg(logic [2:0] idx, logic [12:0] data);
      @(negedge clock);
      csr_write = 1;
      csr_index = idx;
      csr_wdata = data;
      @(posedge clock);
      sb.write_reg(idx, data);
   endtask

   task automatic configure(int ic, int oc, int g, int h, int w, int k, int s, int p);
      drain();
      write_reg(gc2d_pkg::CFG_IN_CHANNELS, 13'(ic));
      write_reg(gc2d_pkg::CFG_OUT_CHANNELS, 13'(oc));
      write_reg(gc2d_pkg::CFG_GROUPS, 13'(g));
      write_reg(gc2d_pkg::CFG_IN_HEIGHT, 13'(h));
      write_reg(gc2d_pkg::CFG_IN_WIDTH, 13'(w));
      write_reg(gc2d_pkg::CFG_KERNEL_SHAPE, 13'(k));
      write_reg(gc2d_pkg::CFG_STRIDE_SHAPE, 13'(s));
      write_reg(gc2d_pkg::CFG_PAD_SHAPE, 13'(p));
      @(negedge clock);
      csr_write = 0;
      phase_count++;
      quiet = (phase_count % 3 == 0);
   endtask

   task automatic random_items(int n);
      int r, rows, cols;
      repeat (n) begin
         r = $urandom_range(0, 99);
         rows = sb.out_rows();
         cols = sb.out_cols();
         if (r < 55 && !sb.cfg_bad() && rows > 0 && cols > 0)
            compute($urandom_range(0, sb.och - 1), $urandom_range(0, rows - 1),
                    $urandom_range(0, cols - 1));
         else if (r < 70)
            compute($urandom, $urandom, $urandom);
         else
            load($urandom_range(0, 2), $urandom, $urandom);
      end
   endtask

   initial begin
      int g;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 0;

      // Directed part at the reset configuration: one channel, 1x1 image and kernel.
      load(gc2d_pkg::KIND_LOAD_ACT, 0, 32'h7fffffff);
      load(gc2d_pkg::KIND_LOAD_WEIGHT, 0, 32'h80000000);
      load(gc2d_pkg::KIND_LOAD_BIAS, 0, 32'hffffffff);
      compute(0, 0, 0);
      compute(1, 0, 0);
      compute(0, 1, 0);
      compute(0, 0, 1);
      compute(63, 12'hfff, 12'hfff);
      load(gc2d_pkg::KIND_LOAD_BIAS, 63, 32'h12345678);
      load(gc2d_pkg::KIND_LOAD_BIAS, 12'hfff, 32'hdeadbeef);
      load(gc2d_pkg::KIND_LOAD_ACT, 12'hfff, 32'h80000000);
      load(gc2d_pkg::KIND_LOAD_WEIGHT, 12'hfff, 32'h7fffffff);
      load(gc2d_pkg::KIND_LOAD_ACT, 0, 32'h80000000);
      load(gc2d_pkg::KIND_LOAD_WEIGHT, 0, 32'h80000000);
      compute(0, 0, 0);
      load(gc2d_pkg::KIND_LOAD_BIAS, 0, 32'h80000000);
      load(gc2d_pkg::KIND_LOAD_WEIGHT, 0, 32'hffffffff);
      compute(0, 0, 0);

      // Fixed settings covering the extremes and the unusable configurations.
      configure(4, 4, 2, 5, 6, 'h33, 'h21, 'h11);
      random_items(40);
      configure(64, 64, 64, 4096, 1, 'hf1, 'hf1, 'hf0);
      random_items(40);
      configure(1, 1, 1, 1, 1, 'hff, 'hff, 'hff);
      random_items(15);
      configure(64, 1, 1, 1, 8191, 'h11, 'h11, 'h00);
      random_items(30);
      configure(4, 6, 4, 3, 3, 'h22, 'h11, 'h00);
      random_items(15);
      configure(100, 1, 1, 2, 2, 'h11, 'h11, 'h00);
      random_items(10);
      configure(2, 2, 1, 0, 4, 'h02, 'h10, 'h00);
      random_items(10);
      configure(1, 1, 1, 2, 2, 'h55, 'h11, 'h00);
      random_items(10);
      configure(0, 0, 0, 1, 1, 'h00, 'h00, 'h00);
      random_items(5);

      // Random settings; the first phase also makes the receiver hold off for long.
      configure(4, 4, 2, 4, 4, 'h22, 'h11, 'h11);
      hold_req = 1;
      random_items(50);
      while (item_count < RandomItems) begin
         g = 1 << $urandom_range(0, 2);
         configure(g * $urandom_range(1, 3), g * $urandom_range(1, 3), g,
                   $urandom_range(1, 8), $urandom_range(1, 8),
                   $urandom_range(1, 3) * 16 + $urandom_range(1, 3),
                   $urandom_range(1, 3) * 16 + $urandom_range(1, 3),
                   $urandom_range(0, 2) * 16 + $urandom_range(0, 2));
         random_items(50);
      end
      configure(1, 1, 1, 1, 1, 'h11, 'h11, 'h00);
      random_items(10);

      drain();
      $display("Covered %0d requests over %0d settings: %0d loads, %0d computes.",
               item_count, phase_count, sb.n_loads, sb.n_computes);
      $display("Checked %0d responses, %0d of them flagged as bad positions.",
               sb.n_checked, sb.n_flagged);
      if (sb.errors == 0 && sb.pending_q.size() == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end
endmodule

`default_nettype wire
